// ----- rtl/deq_pkg.sv -----
package deq_pkg;

  localparam int CAPACITY = 16;

  localparam int DATA_W   = 32;
  localparam int MODE_W   = 2;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 5;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int SUM_W = CNT_W + 1;

  localparam int OUT_BITS    = DATA_W + STATUS_W + OCC_W;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_BITS;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH_FRONT = 2'd0,
    MODE_PUSH_REAR  = 2'd1,
    MODE_POP_FRONT  = 2'd2,
    MODE_POP_REAR   = 2'd3
  } deq_mode_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } deq_status_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_READ = 1'b1
  } deq_state_t;

  function automatic logic [OCC_W-1:0] to_occ(input logic [CNT_W-1:0] cnt);
    logic [OCC_W+CNT_W-1:0] wide;
    wide = (OCC_W + CNT_W)'(cnt);
    return wide[OCC_W-1:0];
  endfunction

endpackage

// ----- rtl/deq_ram.sv -----
module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [WIDTH-1:0]  wdata,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- rtl/double_ended_queue.sv -----
// a push or an error result is registered and offered in the cycle after the item is taken
// a pop reads its item into the ram read register, then loads it into the output register
// throughput: one push per cycle unless the output stalls, input held off during the ram read
// an item is taken only while the output register is free or being emptied
// synchronous reset empties the queue (head and count to zero) and drops any pending result
module double_ended_queue (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // push_value
  input  logic [deq_pkg::DATA_W-1:0]         s_axis_tdata,
  // mode
  input  logic [deq_pkg::MODE_W-1:0]         s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // pop_value, status, occupancy, zero pad
  output logic [deq_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
  import deq_pkg::*;

  deq_state_t        state, state_next;
  logic [IDX_W-1:0]  head, head_next;
  logic [CNT_W-1:0]  count, count_next;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_addr;
  logic [DATA_W-1:0] ram_rdata;

  logic              out_valid;
  logic [DATA_W-1:0] out_value, out_value_next;
  deq_status_t       out_status, out_status_next;
  logic [OCC_W-1:0]  out_occ, out_occ_next;
  logic              out_load;

  logic              in_accept;
  deq_mode_t         in_mode;
  logic              full, empty;
  logic [IDX_W-1:0]  head_dec, head_inc;
  logic [SUM_W-1:0]  push_sum, push_wrap, pop_sum, pop_wrap;
  logic [IDX_W-1:0]  rear_push_idx, rear_pop_idx;

  assign in_mode   = deq_mode_t'(s_axis_tuser);
  assign full      = (count >= CNT_W'(CAPACITY));
  assign empty     = (count == '0);
  assign head_dec  = (head == '0) ? IDX_W'(CAPACITY - 1) : head - IDX_W'(1);
  assign head_inc  = (head == IDX_W'(CAPACITY - 1)) ? '0 : head + IDX_W'(1);

  assign push_sum  = SUM_W'(head) + SUM_W'(count);
  assign push_wrap = (push_sum >= SUM_W'(CAPACITY)) ? push_sum - SUM_W'(CAPACITY) : push_sum;
  assign pop_sum   = SUM_W'(head) + SUM_W'(count - CNT_W'(1));
  assign pop_wrap  = (pop_sum >= SUM_W'(CAPACITY)) ? pop_sum - SUM_W'(CAPACITY) : pop_sum;
  assign rear_push_idx = push_wrap[IDX_W-1:0];
  assign rear_pop_idx  = pop_wrap[IDX_W-1:0];

  assign s_axis_tready = (state == ST_IDLE) && (!out_valid || m_axis_tready);
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  deq_ram #(
    .WIDTH(DATA_W),
    .DEPTH(CAPACITY)
  ) u_deq_ram (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(s_axis_tdata),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      head  <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      head  <= head_next;
      count <= count_next;
    end
  end

  always_comb begin
    state_next      = state;
    head_next       = head;
    count_next      = count;
    ram_we          = 1'b0;
    ram_addr        = head;
    out_load        = 1'b0;
    out_value_next  = '0;
    out_status_next = STATUS_OK;
    out_occ_next    = to_occ(count);
    case (state)
      ST_IDLE: begin
        if (in_accept) begin
          case (in_mode)
            MODE_PUSH_FRONT: begin
              out_load = 1'b1;
              if (full) begin
                out_status_next = STATUS_FULL;
              end else begin
                head_next    = head_dec;
                ram_addr     = head_dec;
                ram_we       = 1'b1;
                count_next   = count + CNT_W'(1);
                out_occ_next = to_occ(count + CNT_W'(1));
              end
            end
            MODE_PUSH_REAR: begin
              out_load = 1'b1;
              if (full) begin
                out_status_next = STATUS_FULL;
              end else begin
                ram_addr     = rear_push_idx;
                ram_we       = 1'b1;
                count_next   = count + CNT_W'(1);
                out_occ_next = to_occ(count + CNT_W'(1));
              end
            end
            MODE_POP_FRONT: begin
              if (empty) begin
                out_load        = 1'b1;
                out_status_next = STATUS_EMPTY;
              end else begin
                ram_addr   = head;
                head_next  = head_inc;
                count_next = count - CNT_W'(1);
                state_next = ST_READ;
              end
            end
            MODE_POP_REAR: begin
              if (empty) begin
                out_load        = 1'b1;
                out_status_next = STATUS_EMPTY;
              end else begin
                ram_addr   = rear_pop_idx;
                count_next = count - CNT_W'(1);
                state_next = ST_READ;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_READ: begin
        out_load       = 1'b1;
        out_value_next = ram_rdata;
        state_next     = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_value  <= out_value_next;
      out_status <= out_status_next;
      out_occ    <= out_occ_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_occ, out_status, out_value};

endmodule

// ----- rtl/deq_checker.sv -----
module deq_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [deq_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import deq_pkg::*;

  logic [DATA_W-1:0]   chk_value;
  logic [STATUS_W-1:0] chk_status;
  logic [OCC_W-1:0]    chk_occ;

  assign chk_value  = m_axis_tdata[DATA_W-1:0];
  assign chk_status = m_axis_tdata[DATA_W+STATUS_W-1:DATA_W];
  assign chk_occ    = m_axis_tdata[DATA_W+STATUS_W+OCC_W-1:DATA_W+STATUS_W];

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // reset leaves no result pending
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // errors never carry a value
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (chk_status != STATUS_OK) |-> (chk_value == '0))
    else $error("error result with nonzero value");

  // occupancy within capacity
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (CAPACITY > 31) || (chk_occ <= OCC_W'(CAPACITY)))
    else $error("occupancy beyond capacity");

  // an empty error always reports an empty queue
  a_status_occ: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (chk_status == STATUS_EMPTY) |-> (chk_occ == '0))
    else $error("empty error with nonzero occupancy");

endmodule

bind double_ended_queue deq_checker u_deq_checker (
  .clk          (clk),
  .rst          (rst),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);
